[sv/rar_pkg.sv]
// ============================================================================
// rar_pkg: shared types and constants for the rational arithmetic block
// Holds the operation codes and the fixed result field widths.
// ============================================================================
package rar_pkg;

    localparam int RES_NUM_W = 34;
    localparam int RES_DEN_W = 33;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    // Operation of the shared divider.
    typedef struct packed {
        logic start;
    } t_div_ctl;

endpackage

[sv/rar_divu.sv]
// ============================================================================
// rar_divu: iterative unsigned divider
// Restoring division, one quotient bit per cycle; gives quotient and remainder.
// ============================================================================
module rar_divu import rar_pkg::*; #(
    parameter int W = 66
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_div_ctl     i_ctl,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q;
    logic [W-1:0]  r_r;
    logic [W-1:0]  r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    n_trial;

    assign n_trial = {r_r, r_q[W-1]} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                if (n_trial[W]) begin
                    r_r <= {r_r[W-2:0], r_q[W-1]};
                    r_q <= {r_q[W-2:0], 1'b0};
                end else begin
                    r_r <= n_trial[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

[sv/rational_arith_reduce.sv]
// ============================================================================
// rational_arith_reduce: exact fraction arithmetic with GCD reduction
// Forms the result fraction from operand products, reduces it by Euclid's algorithm and
// returns a signed numerator over a positive denominator.
// ============================================================================
//  Channel | Direction | Handshake          | Payload
//  request | in        | i_valid / o_ready  | i_req_type, i_a_num, i_a_den, i_b_num, i_b_den
//  result  | out       | o_valid / i_ready  | o_res_num, o_res_den, o_div_error
//
// One request at a time. The products are formed on a single shared
// multiplier, one product per cycle. Euclid's algorithm then runs on the
// shared bit-serial divider, one remainder per division, followed by two
// exact divisions of the numerator and denominator by the GCD. A zero
// numerator or denominator skips the divider. Reset is synchronous and
// active low and empties the block. A held result sits in the output register
// while the next request is worked on; that request then waits at the end
// until the result side takes the first.
module rational_arith_reduce import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_req_type,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [RES_NUM_W-1:0] o_res_num,
    output logic [RES_DEN_W-1:0]        o_res_den,
    output logic                        o_div_error
);
    localparam int OW = OPERAND_WIDTH;
    localparam int PW = 2 * OW;          // product magnitude width
    localparam int MW = PW + 1;          // sum magnitude width
    localparam int DW = MW + 1;          // divider width, keeps a headroom bit

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL0  = 10'b0000000010,
        S_MUL1  = 10'b0000000100,
        S_MUL2  = 10'b0000001000,
        S_SUM   = 10'b0000010000,
        S_GCD   = 10'b0000100000,
        S_GWAIT = 10'b0001000000,
        S_DIVN  = 10'b0010000000,
        S_DIVD  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;

    // Operand signs and magnitudes.
    logic [2:0]    r_op;
    logic          r_sa, r_sad, r_sb, r_sbd;
    logic [OW-1:0] r_ma, r_mad, r_mb, r_mbd;
    logic [PW-1:0] r_p0, r_p1, r_p2;
    logic          r_nneg, r_dneg;
    logic [MW-1:0] r_nm, r_dm;
    logic [MW-1:0] r_x, r_y, r_g;
    logic [MW-1:0] r_qn;
    logic          r_valid;
    logic signed [RES_NUM_W-1:0] r_res_num;
    logic [RES_DEN_W-1:0]        r_res_den;
    logic          r_err;
    logic signed [RES_NUM_W-1:0] r_out_num;
    logic [RES_DEN_W-1:0]        r_out_den;
    logic          r_out_err;

    function automatic logic [OW-1:0] mag(input logic [OW-1:0] v);
        return v[OW-1] ? (~v + 1'b1) : v;
    endfunction

    // Shared multiplier: operands selected by state.
    logic [OW-1:0] n_ma, n_mb;
    logic [PW-1:0] n_prod;
    always_comb begin
        unique case (r_state)
            S_MUL0:  begin n_ma = r_ma;  n_mb = (r_op == OP_MUL) ? r_mb : r_mbd; end
            S_MUL1:  begin n_ma = r_mad; n_mb = (r_op == OP_DIV) ? r_mb : r_mbd; end
            default: begin n_ma = r_mad; n_mb = r_mb; end
        endcase
    end
    assign n_prod = PW'(n_ma) * PW'(n_mb);

    // Shared divider. Each new division starts in the cycle the previous one
    // reports done, so Euclid's steps run back to back.
    t_div_ctl      n_ctl;
    logic [DW-1:0] n_dvd, n_dvs, w_quot, w_rem;
    logic          w_done;

    always_comb begin
        n_ctl.start = 1'b0;
        n_dvd = {1'b0, r_x};
        n_dvs = {1'b0, r_y};
        case (r_state)
            S_GCD: begin
                if (r_dm != '0 && r_nm != '0) begin
                    n_ctl.start = 1'b1;
                    n_dvd = {1'b0, r_nm};
                    n_dvs = {1'b0, r_dm};
                end
            end
            S_GWAIT: begin
                if (w_done) begin
                    n_ctl.start = 1'b1;
                    if (w_rem[MW-1:0] == '0) begin
                        n_dvd = {1'b0, r_nm};
                        n_dvs = {1'b0, r_y};
                    end else begin
                        n_dvd = {1'b0, r_y};
                        n_dvs = {1'b0, w_rem[MW-1:0]};
                    end
                end
            end
            S_DIVN: begin
                if (w_done) begin
                    n_ctl.start = 1'b1;
                    n_dvd = {1'b0, r_dm};
                    n_dvs = {1'b0, r_g};
                end
            end
            default: ;
        endcase
    end

    rar_divu #(.W(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (n_ctl),
        .i_dividend (n_dvd),
        .i_divisor  (n_dvs),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Signed sum of the two cross products an*bd and ad*bn.
    logic          n_bneg, n_fneg;
    logic [MW-1:0] n_sum;
    logic          n_sneg;
    always_comb begin
        n_fneg = (r_sa != r_sbd) && (r_p0 != '0);
        n_bneg = ((r_sad != r_sb) && (r_p2 != '0)) ^ ((r_op == OP_SUB) && (r_p2 != '0));
        if (n_fneg == n_bneg) begin
            n_sum  = MW'(r_p0) + MW'(r_p2);
            n_sneg = n_fneg;
        end else if (r_p0 >= r_p2) begin
            n_sum  = MW'(r_p0 - r_p2);
            n_sneg = n_fneg;
        end else begin
            n_sum  = MW'(r_p2 - r_p0);
            n_sneg = n_bneg;
        end
        if (n_sum == '0) n_sneg = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op  <= i_req_type;
                        r_sa  <= i_a_num[OW-1];
                        r_sad <= i_a_den[OW-1];
                        r_sb  <= i_b_num[OW-1];
                        r_sbd <= i_b_den[OW-1];
                        r_ma  <= mag(i_a_num);
                        r_mad <= mag(i_a_den);
                        r_mb  <= mag(i_b_num);
                        r_mbd <= mag(i_b_den);
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin r_p0 <= n_prod; r_state <= S_MUL1; end
                S_MUL1: begin r_p1 <= n_prod; r_state <= S_MUL2; end
                S_MUL2: begin r_p2 <= n_prod; r_state <= S_SUM; end
                S_SUM: begin
                    // r_p0: an*bd (an*bn for multiply), r_p1: ad*bd (ad*bn for
                    // divide), r_p2: ad*bn
                    case (r_op)
                        OP_ADD, OP_SUB: begin
                            r_nm <= n_sum; r_nneg <= n_sneg;
                            r_dm <= MW'(r_p1);
                            r_dneg <= r_sad != r_sbd;
                        end
                        OP_MUL: begin
                            r_nm <= MW'(r_p0); r_nneg <= r_sa != r_sb;
                            r_dm <= MW'(r_p1); r_dneg <= r_sad != r_sbd;
                        end
                        OP_DIV: begin
                            r_nm <= MW'(r_p0); r_nneg <= r_sa != r_sbd;
                            r_dm <= MW'(r_p1); r_dneg <= r_sad != r_sb;
                        end
                        default: begin
                            r_nm <= MW'(r_ma); r_nneg <= r_sa;
                            r_dm <= MW'(r_mad); r_dneg <= r_sad;
                        end
                    endcase
                    r_state <= S_GCD;
                end
                S_GCD: begin
                    if (r_dm == '0) begin
                        r_res_num <= '0; r_res_den <= RES_DEN_W'(1); r_err <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_nm == '0) begin
                        r_res_num <= '0; r_res_den <= RES_DEN_W'(1); r_err <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        // The first remainder step starts in this cycle.
                        r_x <= r_nm; r_y <= r_dm;
                        r_state <= S_GWAIT;
                    end
                end
                S_GWAIT: begin
                    if (w_done) begin
                        if (w_rem[MW-1:0] == '0) begin
                            r_g <= r_y;
                            r_state <= S_DIVN;
                        end else begin
                            r_x <= r_y;
                            r_y <= w_rem[MW-1:0];
                        end
                    end
                end
                S_DIVN: begin
                    if (w_done) begin
                        r_qn <= w_quot[MW-1:0];
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (w_done) begin
                        r_res_num <= (r_nneg != r_dneg) ? (~RES_NUM_W'(r_qn) + 1'b1)
                                                         : RES_NUM_W'(r_qn);
                        r_res_den <= RES_DEN_W'(w_quot[MW-1:0]);
                        r_err <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_valid   <= 1'b1;
                        r_out_num <= r_res_num;
                        r_out_den <= r_res_den;
                        r_out_err <= r_err;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_valid;
    assign o_res_num   = r_out_num;
    assign o_res_den   = r_out_den;
    assign o_div_error = r_out_err;
endmodule

[sv/rar_checker.sv]
// ============================================================================
// rar_checker: port-level checks for the rational arithmetic block
// Watches the handshake and result fields over time.
// ============================================================================
module rar_checker import rar_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [RES_NUM_W-1:0] o_res_num,
    input logic [RES_DEN_W-1:0] o_res_den,
    input logic                 o_div_error
);
    // Result held until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_num) && $stable(o_res_den))
        else $error("result changed while stalled");
    // Error results are always 0/1.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_error |-> o_res_num == '0 && o_res_den == RES_DEN_W'(1))
        else $error("error result not 0/1");
    // A delivered denominator is never zero.
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res_den != '0)
        else $error("zero denominator delivered");
    // Accepting a request drops ready for the work that follows.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after accept");
endmodule

bind rational_arith_reduce rar_checker u_rar_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_res_num   (o_res_num),
    .o_res_den   (o_res_den),
    .o_div_error (o_div_error)
);
